@@ rtl/fta_pkg.sv @@
// Shared types, widths and reset values for the FIRE time-step adapter.
// Used by fta_csr, fta_step and fire_timestep_adapter_core; no dependencies.
package fta_pkg;

   localparam int unsigned POWER_W   = 32;
   localparam int unsigned DT_W      = 32;
   localparam int unsigned GROW_W    = 18;
   localparam int unsigned FACTOR_W  = 16;
   localparam int unsigned ALPHA_W   = 16;
   localparam int unsigned DELAY_W   = 16;
   localparam int unsigned FRAC_W    = 16;
   localparam int unsigned STEP_W    = 17;
   localparam int unsigned DOWN_W    = 17;
   localparam int unsigned UP_W      = 16;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned REQ_DATA_W = 32;
   localparam int unsigned RSP_DATA_W = 56;

   localparam int unsigned STALL_LIMIT_DEF = 2000;
   localparam bit          GRACE_EN_DEF    = 1'b1;

   // register indexes on the csr port
   localparam logic [CSR_ADDR_W-1:0] CSR_DT_INIT     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DT_MAX      = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_DT_MIN      = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_DT_GROW     = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_DT_CUT      = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIX_INIT    = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIX_DECAY   = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_DELAY_STEPS = 3'd7;

   // reset values: dt 1.0, dt_max 10.0, dt_min 0.02, grow 1.1, shrink 0.5,
   // alpha 0.25, alpha decay 0.99, delay 20 steps
   localparam logic [DT_W-1:0]     DT_INIT_RST     = 32'd16777216;
   localparam logic [DT_W-1:0]     DT_MAX_RST      = 32'd167772160;
   localparam logic [DT_W-1:0]     DT_MIN_RST      = 32'd335544;
   localparam logic [GROW_W-1:0]   DT_GROW_RST     = 18'd72090;
   localparam logic [FACTOR_W-1:0] DT_CUT_RST      = 16'd32768;
   localparam logic [ALPHA_W-1:0]  MIX_INIT_RST    = 16'd16384;
   localparam logic [FACTOR_W-1:0] MIX_DECAY_RST   = 16'd64881;
   localparam logic [DELAY_W-1:0]  DELAY_STEPS_RST = 16'd20;

   typedef struct packed {
      logic [DT_W-1:0]     dt_init;
      logic [DT_W-1:0]     dt_max;
      logic [DT_W-1:0]     dt_min;
      logic [GROW_W-1:0]   dt_grow;
      logic [FACTOR_W-1:0] dt_cut;
      logic [ALPHA_W-1:0]  mix_init;
      logic [FACTOR_W-1:0] mix_decay;
      logic [DELAY_W-1:0]  delay_steps;
   } cfg_type;

   typedef struct packed {
      logic [DT_W-1:0]    dt;
      logic [ALPHA_W-1:0] alpha;
      logic [DOWN_W-1:0]  down_run;
      logic [UP_W-1:0]    up_run;
      logic [STEP_W-1:0]  step;
   } state_type;

   typedef struct packed {
      logic [ALPHA_W-1:0] mix_coeff;
      logic [DT_W-1:0]    time_step;
      logic               run_ok;
      logic               uphill;
   } result_type;

endpackage

@@ rtl/fta_csr.sv @@
// Configuration register file of the FIRE time-step adapter.
// Depends on fta_pkg for register indexes, widths and reset values.
module fta_csr import fta_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_DT_INIT:     cfg_in.dt_init     = csr_wdata[DT_W-1:0];
            CSR_DT_MAX:      cfg_in.dt_max      = csr_wdata[DT_W-1:0];
            CSR_DT_MIN:      cfg_in.dt_min      = csr_wdata[DT_W-1:0];
            CSR_DT_GROW:     cfg_in.dt_grow     = csr_wdata[GROW_W-1:0];
            CSR_DT_CUT:      cfg_in.dt_cut      = csr_wdata[FACTOR_W-1:0];
            CSR_MIX_INIT:    cfg_in.mix_init    = csr_wdata[ALPHA_W-1:0];
            CSR_MIX_DECAY:   cfg_in.mix_decay   = csr_wdata[FACTOR_W-1:0];
            CSR_DELAY_STEPS: cfg_in.delay_steps = csr_wdata[DELAY_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dt_init     <= DT_INIT_RST;
         cfg_ff.dt_max      <= DT_MAX_RST;
         cfg_ff.dt_min      <= DT_MIN_RST;
         cfg_ff.dt_grow     <= DT_GROW_RST;
         cfg_ff.dt_cut      <= DT_CUT_RST;
         cfg_ff.mix_init    <= MIX_INIT_RST;
         cfg_ff.mix_decay   <= MIX_DECAY_RST;
         cfg_ff.delay_steps <= DELAY_STEPS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/fta_step.sv @@
// Single-step update of the FIRE time-step adapter: counters, dt and alpha.
// Depends on fta_pkg for the state, configuration and result structs.
module fta_step import fta_pkg::*; #(
   parameter int unsigned STALL_LIMIT = STALL_LIMIT_DEF,
   parameter bit          GRACE_EN    = GRACE_EN_DEF
) (
   input  logic [POWER_W-1:0] power,
   input  cfg_type            cfg,
   input  state_type          state,
   output state_type          state_nx,
   output result_type         result
);

   localparam int unsigned GROW_P_W   = DT_W + GROW_W;
   localparam int unsigned SHRINK_P_W = DT_W + FACTOR_W;
   localparam int unsigned ALPHA_P_W  = ALPHA_W + FACTOR_W;
   localparam int unsigned GROW_Q_W   = GROW_P_W - FRAC_W;
   localparam logic [UP_W-1:0] STALL_LIM_C = UP_W'(STALL_LIMIT);

   logic                  uphill;
   logic [STEP_W-1:0]     step_nx;
   logic [DOWN_W-1:0]     down_inc;
   logic [UP_W-1:0]       up_inc;
   logic [GROW_P_W-1:0]   grow_prod;
   logic [SHRINK_P_W-1:0] shrink_prod;
   logic [ALPHA_P_W-1:0]  alpha_prod;
   logic [GROW_Q_W-1:0]   grow_q;
   logic [DT_W-1:0]       shrink_q;
   logic                  grace;

   assign uphill = (power == '0) || power[POWER_W-1];

   // saturate the counters at all ones
   assign step_nx  = (state.step == '1) ? state.step : state.step + STEP_W'(1);
   assign down_inc = (state.down_run == '1) ? state.down_run
                                            : state.down_run + DOWN_W'(1);
   assign up_inc   = (state.up_run == '1) ? state.up_run : state.up_run + UP_W'(1);

   assign grow_prod   = GROW_P_W'(state.dt) * GROW_P_W'(cfg.dt_grow);
   assign shrink_prod = SHRINK_P_W'(state.dt) * SHRINK_P_W'(cfg.dt_cut);
   assign alpha_prod  = ALPHA_P_W'(state.alpha) * ALPHA_P_W'(cfg.mix_decay);
   assign grow_q      = grow_prod[GROW_P_W-1:FRAC_W];
   assign shrink_q    = shrink_prod[SHRINK_P_W-1:FRAC_W];

   assign grace = GRACE_EN && (step_nx < STEP_W'(cfg.delay_steps));

   always_comb begin
      state_nx      = state;
      state_nx.step = step_nx;
      if (!uphill) begin
         state_nx.down_run = down_inc;
         state_nx.up_run   = '0;
         if (down_inc > DOWN_W'(cfg.delay_steps)) begin
            state_nx.dt    = (grow_q < GROW_Q_W'(cfg.dt_max)) ? grow_q[DT_W-1:0]
                                                              : cfg.dt_max;
            state_nx.alpha = alpha_prod[ALPHA_P_W-1:FRAC_W];
         end
      end else begin
         state_nx.down_run = '0;
         state_nx.up_run   = up_inc;
         if (!grace) begin
            // hold dt when the shrunk value would drop below the floor
            if (shrink_q >= cfg.dt_min) begin
               state_nx.dt = shrink_q;
            end
            state_nx.alpha = cfg.mix_init;
         end
      end
   end

   always_comb begin
      result.uphill    = uphill;
      result.run_ok    = !uphill || (up_inc <= STALL_LIM_C);
      result.time_step = state_nx.dt;
      result.mix_coeff = state_nx.alpha;
   end

endmodule

@@ rtl/fire_timestep_adapter_core.sv @@
// FIRE 2.0 adaptive time-step controller. Each request carries one relaxation
// step's power (only its sign and whether it is zero are used) and yields one
// response with the uphill flag, the stall flag and the updated dt (Q8.24) and
// alpha (Q0.16). The block takes one request per clock while the response side
// drains; a held response with rsp_tready low stalls it. A taken request sits
// in the input register while the dt, alpha and counter update with its three
// parallel multipliers settles, and the edge that advances it writes the state
// and the response register together. The response register frees its slot in
// the same cycle it is taken, so full throughput holds under continuous flow.
// Depends on fta_pkg, fta_csr and fta_step.
module fire_timestep_adapter_core import fta_pkg::*; #(
   parameter int unsigned STALL_LIMIT = STALL_LIMIT_DEF,
   parameter bit          GRACE_EN    = GRACE_EN_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [31:0] power
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [0] uphill, [1] not stalled,
                                              // [33:2] time_step, [49:34] mix_coeff,
                                              // [55:50] zero
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned RES_W = $bits(result_type);

   cfg_type            cfg;
   logic               in_valid_ff, in_valid_in;
   logic [POWER_W-1:0] power_ff, power_in;
   logic               out_valid_ff, out_valid_in;
   result_type         res_ff, res_in;
   state_type          state_ff, state_in;
   state_type          state_nx;
   result_type         res_nx;
   logic               advance;
   logic               req_take;

   fta_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fta_step #(
      .STALL_LIMIT (STALL_LIMIT),
      .GRACE_EN    (GRACE_EN)
   ) u_step (
      .power    (power_ff),
      .cfg      (cfg),
      .state    (state_ff),
      .state_nx (state_nx),
      .result   (res_nx)
   );

   // advance the held request when the response slot is empty or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      power_in     = power_ff;
      out_valid_in = out_valid_ff;
      res_in       = res_ff;
      state_in     = state_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
         power_in    = req_tdata[POWER_W-1:0];
      end
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         res_in       = res_nx;
         state_in     = state_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         out_valid_ff      <= 1'b0;
         state_ff.dt       <= DT_INIT_RST;
         state_ff.alpha    <= MIX_INIT_RST;
         state_ff.down_run <= '0;
         state_ff.up_run   <= '0;
         state_ff.step     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
      power_ff <= power_in;
      res_ff   <= res_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - RES_W)'(0), res_ff};

   // the response on show always matches the state it left behind
   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (res_ff.time_step == state_ff.dt)
                       && (res_ff.mix_coeff == state_ff.alpha))
      else $error("response dt or alpha differs from held state");

   a_uphill_clears_down: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && res_ff.uphill |-> (state_ff.down_run == '0)
                                        && (state_ff.up_run != '0))
      else $error("uphill step left a downhill run or no uphill run");

   a_downhill_clears_up: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !res_ff.uphill |-> (state_ff.up_run == '0)
                                         && res_ff.run_ok
                                         && (state_ff.down_run != '0))
      else $error("downhill step left an uphill run or a stall");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("state moved without a request advancing");

endmodule

@@ tb/sv/tb_fire_timestep_adapter_core.sv @@
`timescale 1ns / 1ps
// Self-checking bench for fire_timestep_adapter_core. It streams power requests and
// predicts the dt, alpha, uphill and stall fields of each response. It compares them.
// Depends on fta_pkg and the core RTL.
module tb_fire_timestep_adapter_core;
   import fta_pkg::*;

   localparam int unsigned QUIET_LIMIT = 1000;
   localparam int unsigned MAX_REPORTS = 50;

   typedef struct packed {
      logic               drain;
      logic [POWER_W-1:0] power;
   } power_req_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   power_req_type power_backlog[$];
   power_req_type next_req;
   result_type    step_expected[$];
   result_type    want, got;
   cfg_type       fire_cfg;
   state_type     fire_st;
   int unsigned   req_gap = 0, sink_hold = 0, sink_draw = 0;
   int unsigned   n_sent = 0, n_checked = 0, n_errors = 0, n_settings = 0;
   int unsigned   quiet_cycles = 0;
   bit            calm = 1'b0;

   fire_timestep_adapter_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly no gap, sometimes a short one, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(25, 4);
   endfunction

   function automatic logic [31:0] pick32(input logic [31:0] lo, hi, mid_lo, mid_hi);
      int unsigned r;
      r = $urandom_range(5);
      if (r == 0) return lo;
      if (r == 1) return hi;
      return $urandom_range(mid_hi, mid_lo);
   endfunction

   // advance the predicted controller by one step and return its response
   function automatic result_type fire_update(input logic [POWER_W-1:0] power);
      result_type                        res;
      logic                              up;
      logic                              grace;
      logic [DT_W+GROW_W-1:0]            grow_prod;
      logic [DT_W+GROW_W-FRAC_W-1:0]     grown;
      logic [DT_W+FACTOR_W-1:0]          shrink_prod;
      logic [2*ALPHA_W-1:0]              decay_prod;
      up = (power == '0) || power[POWER_W-1];
      res.run_ok = 1'b1;
      if (fire_st.step != {STEP_W{1'b1}})
         fire_st.step = fire_st.step + 1'b1;
      if (!up) begin
         if (fire_st.down_run != {DOWN_W{1'b1}})
            fire_st.down_run = fire_st.down_run + 1'b1;
         fire_st.up_run = '0;
         if (fire_st.down_run > {1'b0, fire_cfg.delay_steps}) begin
            grow_prod = {{GROW_W{1'b0}}, fire_st.dt} * {{DT_W{1'b0}}, fire_cfg.dt_grow};
            grown = grow_prod[DT_W+GROW_W-1:FRAC_W];
            fire_st.dt = (grown < {2'b00, fire_cfg.dt_max}) ? grown[DT_W-1:0]
                                                             : fire_cfg.dt_max;
            decay_prod = {{ALPHA_W{1'b0}}, fire_st.alpha}
                       * {{ALPHA_W{1'b0}}, fire_cfg.mix_decay};
            fire_st.alpha = decay_prod[2*ALPHA_W-1:FRAC_W];
         end
      end else begin
         fire_st.down_run = '0;
         if (fire_st.up_run != {UP_W{1'b1}})
            fire_st.up_run = fire_st.up_run + 1'b1;
         res.run_ok = (fire_st.up_run <= UP_W'(STALL_LIMIT_DEF));
         grace = GRACE_EN_DEF && (fire_st.step < {1'b0, fire_cfg.delay_steps});
         if (!grace) begin
            shrink_prod = {{FACTOR_W{1'b0}}, fire_st.dt} * {{DT_W{1'b0}}, fire_cfg.dt_cut};
            if (shrink_prod[DT_W+FACTOR_W-1:FRAC_W] >= fire_cfg.dt_min)
               fire_st.dt = shrink_prod[DT_W+FACTOR_W-1:FRAC_W];
            fire_st.alpha = fire_cfg.mix_init;
         end
      end
      res.uphill    = up;
      res.time_step = fire_st.dt;
      res.mix_coeff = fire_st.alpha;
      return res;
   endfunction

   task automatic check_field(input string fld, input logic [31:0] exp_v, act_v);
      if (exp_v !== act_v) begin
         n_errors++;
         if (n_errors <= MAX_REPORTS)
            $display("[%0t] %s: expected %h, actual %h (response %0d)",
                     $time, fld, exp_v, act_v, n_checked);
      end
   endtask

   task automatic queue_power(input logic [POWER_W-1:0] p, input bit hold = 1'b0);
      power_backlog.push_back('{drain: hold, power: p});
   endtask

   // hold until every request has been answered, then let the pipeline empty
   task automatic settle();
      while (power_backlog.size() != 0 || req_tvalid || n_sent != n_checked)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic put_reg(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
   endtask

   task automatic load_settings(input cfg_type s);
      settle();
      put_reg(CSR_DT_INIT,     s.dt_init);
      put_reg(CSR_DT_MAX,      s.dt_max);
      put_reg(CSR_DT_MIN,      s.dt_min);
      put_reg(CSR_DT_GROW,     CSR_DATA_W'(s.dt_grow));
      put_reg(CSR_DT_CUT,      CSR_DATA_W'(s.dt_cut));
      put_reg(CSR_MIX_INIT,    CSR_DATA_W'(s.mix_init));
      put_reg(CSR_MIX_DECAY,   CSR_DATA_W'(s.mix_decay));
      put_reg(CSR_DELAY_STEPS, CSR_DATA_W'(s.delay_steps));
      @(posedge clock);
      csr_we <= 1'b0;
      n_settings++;
      @(negedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap    <= 0;
      end else begin
         if (req_tvalid && req_tready)
            n_sent <= n_sent + 1;
         if (!req_tvalid || req_tready) begin
            if (req_gap != 0) begin
               req_tvalid <= 1'b0;
               req_gap    <= req_gap - 1;
            end else if (power_backlog.size() != 0 &&
                         !(power_backlog[0].drain && (req_tvalid || n_sent != n_checked))) begin
               next_req = power_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_req.power;
               req_gap    <= calm ? 0 : pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response sink
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         sink_hold  <= 0;
      end else if (calm) begin
         rsp_tready <= 1'b1;
      end else if (sink_hold != 0) begin
         rsp_tready <= 1'b0;
         sink_hold  <= sink_hold - 1;
      end else begin
         sink_draw = pick_gap();
         rsp_tready <= (sink_draw == 0);
         sink_hold  <= (sink_draw == 0) ? 0 : sink_draw - 1;
      end
   end

   // monitor: settings, checks against the oldest prediction, new predictions
   always @(posedge clock) begin
      if (reset) begin
         fire_cfg.dt_init     = DT_INIT_RST;
         fire_cfg.dt_max      = DT_MAX_RST;
         fire_cfg.dt_min      = DT_MIN_RST;
         fire_cfg.dt_grow     = DT_GROW_RST;
         fire_cfg.dt_cut      = DT_CUT_RST;
         fire_cfg.mix_init    = MIX_INIT_RST;
         fire_cfg.mix_decay   = MIX_DECAY_RST;
         fire_cfg.delay_steps = DELAY_STEPS_RST;
         fire_st.dt       = DT_INIT_RST;
         fire_st.alpha    = MIX_INIT_RST;
         fire_st.down_run = '0;
         fire_st.up_run   = '0;
         fire_st.step     = '0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_DT_INIT:     fire_cfg.dt_init     = csr_wdata;
               CSR_DT_MAX:      fire_cfg.dt_max      = csr_wdata;
               CSR_DT_MIN:      fire_cfg.dt_min      = csr_wdata;
               CSR_DT_GROW:     fire_cfg.dt_grow     = csr_wdata[GROW_W-1:0];
               CSR_DT_CUT:      fire_cfg.dt_cut      = csr_wdata[FACTOR_W-1:0];
               CSR_MIX_INIT:    fire_cfg.mix_init    = csr_wdata[ALPHA_W-1:0];
               CSR_MIX_DECAY:   fire_cfg.mix_decay   = csr_wdata[FACTOR_W-1:0];
               CSR_DELAY_STEPS: fire_cfg.delay_steps = csr_wdata[DELAY_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(result_type)-1:0];
            if (step_expected.size() == 0) begin
               n_errors++;
               if (n_errors <= MAX_REPORTS)
                  $display("[%0t] response: expected none, actual %h", $time, rsp_tdata);
            end else begin
               want = step_expected.pop_front();
               check_field("uphill",    32'(want.uphill),    32'(got.uphill));
               check_field("run_ok",    32'(want.run_ok),    32'(got.run_ok));
               check_field("time_step", want.time_step,      got.time_step);
               check_field("mix_coeff", 32'(want.mix_coeff), 32'(got.mix_coeff));
               n_checked <= n_checked + 1;
            end
         end
         if (req_tvalid && req_tready)
            step_expected.push_back(fire_update(req_tdata));
         quiet_cycles <= ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
                         ? 0 : quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("[%0t] watchdog: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      cfg_type            s;
      int unsigned        ph, cnt, len, k, sel;
      logic [POWER_W-1:0] p;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: these steps sit inside the grace period
      queue_power(32'h0000_0000);
      queue_power(32'h8000_0000);
      queue_power(32'h7FFF_FFFF);

      // grace ends at step five; the sixth downhill step in a row grows dt
      s.dt_init     = DT_INIT_RST;
      s.dt_max      = DT_MAX_RST;
      s.dt_min      = DT_MIN_RST;
      s.dt_grow     = DT_GROW_RST;
      s.dt_cut      = DT_CUT_RST;
      s.mix_init    = MIX_INIT_RST;
      s.mix_decay   = MIX_DECAY_RST;
      s.delay_steps = 16'd5;
      load_settings(s);
      queue_power(32'hFFFF_FFFF);
      queue_power(32'h0000_0000);
      queue_power(32'h0000_0001);
      for (k = 0; k < 7; k++)
         queue_power({1'b0, 31'($urandom)} | 32'd1);
      queue_power(32'h8000_0001);

      // cap below the current dt; new start values must not touch dt or alpha yet
      s.dt_init     = 32'd1;
      s.dt_max      = 32'h0040_0000;
      s.mix_init    = 16'hFFFF;
      s.delay_steps = 16'd0;
      load_settings(s);
      queue_power(32'h0000_0001);
      queue_power(32'h0000_0000, 1'b1);
      queue_power(32'h0000_0002);
      queue_power(32'hFFFF_FFFE);
      for (k = 0; k < 5; k++)
         queue_power(32'h4000_0000 >> k);

      for (ph = 0; ph < 10; ph++) begin
         if (ph == 0) begin
            // widest growth: dt climbs to the all-ones cap and never shrinks
            s = '{dt_init: '1, dt_max: '1, dt_min: '1, dt_grow: '1, dt_cut: '1,
                  mix_init: '1, mix_decay: '1, delay_steps: '0};
         end else begin
            // keep growth at or above unity and the floor above zero so dt stays alive
            s.dt_init     = pick32(32'd1, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF);
            s.dt_max      = pick32(32'd1, 32'hFFFF_FFFF, 32'h0010_0000, 32'hFFFF_FFFF);
            s.dt_min      = pick32(32'd1, 32'hFFFF_FFFF, 32'd1, 32'h0100_0000);
            s.dt_grow     = GROW_W'(pick32(32'h1_0000, 32'h3_FFFF, 32'h1_0000, 32'h3_FFFF));
            s.dt_cut      = FACTOR_W'(pick32(32'd0, 32'hFFFF, 32'd0, 32'hFFFF));
            s.mix_init    = ALPHA_W'(pick32(32'd0, 32'hFFFF, 32'd0, 32'hFFFF));
            s.mix_decay   = FACTOR_W'(pick32(32'd0, 32'hFFFF, 32'h8000, 32'hFFFF));
            s.delay_steps = DELAY_W'(pick32(32'd0, 32'hFFFF, 32'd0, 32'd24));
         end
         load_settings(s);
         calm = (ph % 3 == 2);
         cnt = 0;
         while (cnt < 130) begin
            sel = $urandom_range(9);
            if (sel < 6) begin
               len = 30;
               if (s.delay_steps < 24)
                  len = int'(s.delay_steps) + 6;
               len = $urandom_range(len, 1);
            end else if (sel < 9) begin
               len = $urandom_range(4, 1);
            end else begin
               len = 1;
            end
            for (k = 0; k < len; k++) begin
               p = $urandom;
               if (sel < 6) begin
                  p[POWER_W-1] = 1'b0;
                  if (p == '0)
                     p = 32'd1;
               end else if (sel < 9) begin
                  p[POWER_W-1] = 1'b1;
                  if ($urandom_range(7) == 0)
                     p = '0;
               end
               queue_power(p, $urandom_range(99) == 0);
            end
            cnt += len;
         end
      end
      calm = 1'b0;

      // zero factors and floor: dt collapses and alpha decays to nothing
      s = '{dt_init: 32'd1, dt_max: 32'd1, dt_min: '0, dt_grow: '0, dt_cut: '0,
            mix_init: '0, mix_decay: '0, delay_steps: '0};
      load_settings(s);
      for (k = 0; k < 60; k++)
         queue_power($urandom);
      settle();
      repeat (10) @(negedge clock);

      if (step_expected.size() != 0) begin
         n_errors += step_expected.size();
         $display("[%0t] %0d responses never arrived", $time, step_expected.size());
      end
      $display("Checked %0d responses over %0d register settings, covering grace steps,",
               n_checked, n_settings);
      $display("dt caps and floors, zero factors and stalls on both sides of the stream.");
      if (n_errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
